### rtl/gcsac_pkg.sv
package gcsac_pkg;

  localparam int INDEX_BITS_DEF    = 12;
  localparam int CORDIC_STAGES_DEF = 20;

  localparam int FW    = 19;  // offsets and heights
  localparam int IDXW  = 12;  // grid index fields
  localparam int DEPW  = 18;  // detector depth
  localparam int AZW   = 20;  // |z|
  localparam int ZW    = 21;  // signed z
  localparam int SQW   = 42;  // root operand
  localparam int ROOTW = 21;  // rounded root
  localparam int CORW  = 21;  // CORDIC lane operand
  localparam int ANGW  = 23;  // Q16 degree angle, 0 to 90 degrees
  localparam int PHIW  = 25;  // Q16 degree angle, 0 to 360 degrees
  localparam int DISTW = 20;
  localparam int POLW  = 15;
  localparam int COSW  = 17;
  localparam int AZIW  = 17;
  localparam int DIV_NW = 38;
  localparam int DIV_DW = 22;
  localparam int DIV_QB = 17;

  localparam logic [ANGW-1:0]  DEG90     = 23'd5898240;
  localparam logic [PHIW-1:0]  DEG270    = 25'd17694720;
  localparam logic [DISTW-1:0] DIST_MAX  = 20'd1048575;
  localparam logic [POLW-1:0]  POLAR_MAX = 15'd23040;
  localparam logic [AZIW-1:0]  AZI_MAX   = 17'd92160;
  localparam logic [COSW-1:0]  COS_ONE   = 17'd65536;
  localparam logic [DEPW-1:0]  DEPTH_RST = 18'd23648;

  localparam int CFGIW = 3;
  localparam logic [CFGIW-1:0] CFG_SITE_HEIGHT = 3'd0;
  localparam logic [CFGIW-1:0] CFG_DET_DEPTH   = 3'd1;
  localparam logic [CFGIW-1:0] CFG_SITE_COLUMN = 3'd2;
  localparam logic [CFGIW-1:0] CFG_SITE_ROW    = 3'd3;

  typedef struct packed {
    logic [FW-1:0]  ax;
    logic [FW-1:0]  ay;
    logic [AZW-1:0] az;
    logic           negp;
    logic           ge_col;
    logic           ge_row;
  } sq_sb_t;

  typedef struct packed {
    logic [ROOTW-1:0] big;
    logic [AZW-1:0]   az;
    logic             negp;
    logic             ge_col;
    logic             ge_row;
  } co_sb_t;

  typedef struct packed {
    logic [DISTW-1:0] slant;
    logic [POLW-1:0]  polar;
    logic [AZIW-1:0]  azi;
    logic             zero;
  } dv_sb_t;

  // atan(2^-i) in 1/65536 degree.
  function automatic logic [ANGW-1:0] atan_entry(input int i);
    logic [ANGW-1:0] t;
    unique case (i)
      0:  t = 23'd2949120;
      1:  t = 23'd1740967;
      2:  t = 23'd919879;
      3:  t = 23'd466945;
      4:  t = 23'd234379;
      5:  t = 23'd117304;
      6:  t = 23'd58666;
      7:  t = 23'd29335;
      8:  t = 23'd14668;
      9:  t = 23'd7334;
      10: t = 23'd3667;
      11: t = 23'd1833;
      12: t = 23'd917;
      13: t = 23'd458;
      14: t = 23'd229;
      15: t = 23'd115;
      16: t = 23'd57;
      17: t = 23'd29;
      18: t = 23'd14;
      19: t = 23'd7;
      20: t = 23'd4;
      21: t = 23'd2;
      22: t = 23'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### rtl/gcsac_sqrt.sv
module gcsac_sqrt #(
  parameter int W    = gcsac_pkg::SQW,
  parameter int SB_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [1:0][W-1:0]        in_s,
  input  logic [SB_W-1:0]          in_sb,
  output logic                     out_valid,
  output logic [1:0][W/2-1:0]      out_root,
  output logic [1:0][W/2+1:0]      out_rem,
  output logic [SB_W-1:0]          out_sb
);

  localparam int QW = W / 2;
  localparam int RW = QW + 2;
  localparam int N  = QW;

  logic                v_q   [1:N];
  logic [1:0][W-1:0]   s_q   [1:N];
  logic [1:0][RW-1:0]  rem_q [1:N];
  logic [1:0][QW-1:0]  q_q   [1:N];
  logic [SB_W-1:0]     sb_q  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic               cv;
    logic [1:0][W-1:0]  cs;
    logic [1:0][RW-1:0] crem;
    logic [1:0][QW-1:0] cq;
    logic [SB_W-1:0]    csb;
    logic [1:0][RW-1:0] sh;
    logic [1:0][RW-1:0] trial;
    logic [1:0][RW-1:0] rem_next;
    logic [1:0][QW-1:0] q_next;

    if (k == 0) begin : g_first
      assign cv   = in_valid;
      assign cs   = in_s;
      assign crem = '0;
      assign cq   = '0;
      assign csb  = in_sb;
    end else begin : g_rest
      assign cv   = v_q[k];
      assign cs   = s_q[k];
      assign crem = rem_q[k];
      assign cq   = q_q[k];
      assign csb  = sb_q[k];
    end

    // One result bit per stage: bring down two operand bits, try 4q+1.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l]    = {crem[l][RW-3:0], cs[l][W-1-2*k -: 2]};
        trial[l] = {cq[l], 2'b01};
        if (sh[l] >= trial[l]) begin
          rem_next[l] = sh[l] - trial[l];
          q_next[l]   = {cq[l][QW-2:0], 1'b1};
        end else begin
          rem_next[l] = sh[l];
          q_next[l]   = {cq[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[k+1]   <= cs;
        rem_q[k+1] <= rem_next;
        q_q[k+1]   <= q_next;
        sb_q[k+1]  <= csb;
      end
    end
  end

  assign out_valid = v_q[N];
  assign out_root  = q_q[N];
  assign out_rem   = rem_q[N];
  assign out_sb    = sb_q[N];

endmodule

### rtl/gcsac_cordic.sv
module gcsac_cordic #(
  parameter int STAGES = gcsac_pkg::CORDIC_STAGES_DEF,
  parameter int SB_W   = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [1:0][gcsac_pkg::CORW-1:0]      in_x,
  input  logic [1:0][gcsac_pkg::CORW-1:0]      in_y,
  input  logic [SB_W-1:0]                      in_sb,
  output logic                                 out_valid,
  output logic [1:0][gcsac_pkg::ANGW-1:0]      out_angle,
  output logic [SB_W-1:0]                      out_sb
);

  localparam int AW = gcsac_pkg::ANGW + 3;
  localparam int XW = 32;

  logic                        v_q  [1:STAGES];
  logic signed [XW-1:0]        x_q  [1:STAGES][2];
  logic signed [XW-1:0]        y_q  [1:STAGES][2];
  logic signed [AW-1:0]        a_q  [1:STAGES][2];
  logic [1:0]                  yz_q [1:STAGES];
  logic [1:0]                  xz_q [1:STAGES];
  logic [SB_W-1:0]             sb_q [1:STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                 cv;
    logic signed [XW-1:0] cx [2];
    logic signed [XW-1:0] cy [2];
    logic signed [AW-1:0] ca [2];
    logic [1:0]           cyz;
    logic [1:0]           cxz;
    logic [SB_W-1:0]      csb;
    logic signed [XW-1:0] x_next [2];
    logic signed [XW-1:0] y_next [2];
    logic signed [AW-1:0] a_next [2];
    logic signed [AW-1:0] step;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          cx[l]  = $signed({3'b000, in_x[l], 8'h00});
          cy[l]  = $signed({3'b000, in_y[l], 8'h00});
          ca[l]  = '0;
          cyz[l] = (in_y[l] == '0);
          cxz[l] = (in_x[l] == '0);
        end
      end
      assign cv  = in_valid;
      assign csb = in_sb;
    end else begin : g_rest
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          cx[l] = x_q[k][l];
          cy[l] = y_q[k][l];
          ca[l] = a_q[k][l];
        end
      end
      assign cyz = yz_q[k];
      assign cxz = xz_q[k];
      assign cv  = v_q[k];
      assign csb = sb_q[k];
    end

    assign step = $signed({3'b000, gcsac_pkg::atan_entry(k)});

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (cy[l] > 0) begin
          x_next[l] = cx[l] + (cy[l] >>> k);
          y_next[l] = cy[l] - (cx[l] >>> k);
          a_next[l] = ca[l] + step;
        end else begin
          x_next[l] = cx[l] - (cy[l] >>> k);
          y_next[l] = cy[l] + (cx[l] >>> k);
          a_next[l] = ca[l] - step;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          x_q[k+1][l] <= x_next[l];
          y_q[k+1][l] <= y_next[l];
          a_q[k+1][l] <= a_next[l];
        end
        yz_q[k+1] <= cyz;
        xz_q[k+1] <= cxz;
        sb_q[k+1] <= csb;
      end
    end
  end

  // A zero numerator gives 0 and a zero denominator a right angle; otherwise clamp.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      priority if (yz_q[STAGES][l]) begin
        out_angle[l] = '0;
      end else if (xz_q[STAGES][l]) begin
        out_angle[l] = gcsac_pkg::DEG90;
      end else if (a_q[STAGES][l] < 0) begin
        out_angle[l] = '0;
      end else if (a_q[STAGES][l] > $signed({3'b000, gcsac_pkg::DEG90})) begin
        out_angle[l] = gcsac_pkg::DEG90;
      end else begin
        out_angle[l] = a_q[STAGES][l][gcsac_pkg::ANGW-1:0];
      end
    end
  end

  assign out_valid = v_q[STAGES];
  assign out_sb    = sb_q[STAGES];

endmodule

### rtl/gcsac_div.sv
module gcsac_div #(
  parameter int NW   = gcsac_pkg::DIV_NW,
  parameter int DW   = gcsac_pkg::DIV_DW,
  parameter int QB   = gcsac_pkg::DIV_QB,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [QB-1:0]   out_quo,
  output logic [SB_W-1:0] out_sb
);

  logic            v_q   [1:QB];
  logic [NW-1:0]   rem_q [1:QB];
  logic [DW-1:0]   den_q [1:QB];
  logic [QB-1:0]   q_q   [1:QB];
  logic [SB_W-1:0] sb_q  [1:QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic            cv;
    logic [NW-1:0]   crem;
    logic [DW-1:0]   cden;
    logic [QB-1:0]   cq;
    logic [SB_W-1:0] csb;
    logic [NW-1:0]   dsh;
    logic            ge;

    if (k == 0) begin : g_first
      assign cv   = in_valid;
      assign crem = in_num;
      assign cden = in_den;
      assign cq   = '0;
      assign csb  = in_sb;
    end else begin : g_rest
      assign cv   = v_q[k];
      assign crem = rem_q[k];
      assign cden = den_q[k];
      assign cq   = q_q[k];
      assign csb  = sb_q[k];
    end

    assign dsh = {{(NW-DW){1'b0}}, cden} << SH;
    assign ge  = (crem >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? crem - dsh : crem;
        den_q[k+1] <= cden;
        q_q[k+1]   <= {cq[QB-2:0], ge};
        sb_q[k+1]  <= csb;
      end
    end
  end

  assign out_valid = v_q[QB];
  assign out_quo   = q_q[QB];
  assign out_sb    = sb_q[QB];

endmodule

### rtl/grid_cell_slant_angle_calc_core.sv
// Channel  Direction  Handshake             Word
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_stall     cell_column, cell_row, offsets, cell_height
// out      out        out_valid/out_stall   slant_distance, polar_angle, polar_cosine, azimuth
//
// One word enters per cycle unless the output stalls; the stages are three setup stages,
// 21 root stages, one rounding stage, the CORDIC stages, one angle stage, 17 divider
// stages for the cosine and the output register.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_stall is high exactly then.
module grid_cell_slant_angle_calc_core #(
  parameter int INDEX_BITS    = gcsac_pkg::INDEX_BITS_DEF,
  parameter int CORDIC_STAGES = gcsac_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcsac_pkg::CFGIW-1:0]        cfg_index,
  input  logic [gcsac_pkg::FW-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gcsac_pkg::IDXW-1:0]         cell_column,
  input  logic [gcsac_pkg::IDXW-1:0]         cell_row,
  input  logic signed [gcsac_pkg::FW-1:0]    east_offset,
  input  logic signed [gcsac_pkg::FW-1:0]    north_offset,
  input  logic signed [gcsac_pkg::FW-1:0]    cell_height,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gcsac_pkg::DISTW-1:0]        slant_distance,
  output logic [gcsac_pkg::POLW-1:0]         polar_angle,
  output logic [gcsac_pkg::COSW-1:0]         polar_cosine,
  output logic [gcsac_pkg::AZIW-1:0]         azimuth
);

  localparam int K = (INDEX_BITS < gcsac_pkg::IDXW) ? INDEX_BITS : gcsac_pkg::IDXW;
  localparam int FW    = gcsac_pkg::FW;
  localparam int AZW   = gcsac_pkg::AZW;
  localparam int ZW    = gcsac_pkg::ZW;
  localparam int SQW   = gcsac_pkg::SQW;
  localparam int ROOTW = gcsac_pkg::ROOTW;
  localparam int CORW  = gcsac_pkg::CORW;
  localparam int ANGW  = gcsac_pkg::ANGW;
  localparam int PHIW  = gcsac_pkg::PHIW;

  logic en;

  // Configuration registers.
  logic signed [FW-1:0]               site_height;
  logic [gcsac_pkg::DEPW-1:0]         det_depth;
  logic [gcsac_pkg::IDXW-1:0]         site_col;
  logic [gcsac_pkg::IDXW-1:0]         site_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_height <= '0;
      det_depth   <= gcsac_pkg::DEPTH_RST;
      site_col    <= '0;
      site_row    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gcsac_pkg::CFG_SITE_HEIGHT: site_height <= cfg_data;
        gcsac_pkg::CFG_DET_DEPTH:   det_depth   <= cfg_data[gcsac_pkg::DEPW-1:0];
        gcsac_pkg::CFG_SITE_COLUMN: site_col    <= cfg_data[gcsac_pkg::IDXW-1:0];
        gcsac_pkg::CFG_SITE_ROW:    site_row    <= cfg_data[gcsac_pkg::IDXW-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 0: magnitudes, vertical offset and quadrant flags.
  logic signed [ZW-1:0] z;
  gcsac_pkg::sq_sb_t    p0_sb_next;

  assign z = ZW'(cell_height) - (ZW'(site_height) - $signed({3'b000, det_depth}));

  always_comb begin
    p0_sb_next.ax     = east_offset[FW-1]  ? FW'(-east_offset)  : east_offset;
    p0_sb_next.ay     = north_offset[FW-1] ? FW'(-north_offset) : north_offset;
    p0_sb_next.az     = z[ZW-1] ? AZW'(-z) : AZW'(z);
    p0_sb_next.negp   = (east_offset < 0 && north_offset > 0) ||
                        (east_offset > 0 && north_offset < 0) ||
                        (east_offset == 0 && north_offset < 0);
    p0_sb_next.ge_col = cell_column[K-1:0] >= site_col[K-1:0];
    p0_sb_next.ge_row = cell_row[K-1:0] >= site_row[K-1:0];
  end

  logic                p0_v, p1_v, p2_v;
  gcsac_pkg::sq_sb_t   p0_sb, p1_sb, p2_sb;
  logic [2*FW-1:0]     sq_x, sq_y;
  logic [2*AZW-1:0]    sq_z;
  logic [1:0][SQW-1:0] p2_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else if (en) begin
      p0_v <= in_valid;
      p1_v <= p0_v;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_sb   <= p0_sb_next;
      sq_x    <= p0_sb.ax * p0_sb.ax;
      sq_y    <= p0_sb.ay * p0_sb.ay;
      sq_z    <= p0_sb.az * p0_sb.az;
      p1_sb   <= p0_sb;
      p2_s[0] <= SQW'(sq_x) + SQW'(sq_y) + SQW'(sq_z);
      p2_s[1] <= SQW'(sq_x) + SQW'(sq_y);
      p2_sb   <= p1_sb;
    end
  end

  // Integer roots: lane 0 the full distance, lane 1 the horizontal distance.
  logic                    rt_v;
  logic [1:0][SQW/2-1:0]   rt_root;
  logic [1:0][SQW/2+1:0]   rt_rem;
  logic [$bits(gcsac_pkg::sq_sb_t)-1:0] rt_sb_raw;
  gcsac_pkg::sq_sb_t       rt_sb;

  gcsac_sqrt #(
    .W    (SQW),
    .SB_W ($bits(gcsac_pkg::sq_sb_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_v),
    .in_s      (p2_s),
    .in_sb     (p2_sb),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_rem   (rt_rem),
    .out_sb    (rt_sb_raw)
  );

  assign rt_sb = rt_sb_raw;

  // Stage 3: round both roots to nearest.
  logic [1:0][ROOTW-1:0] rnd;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l] = ROOTW'(rt_root[l]) +
               ROOTW'(rt_rem[l] > {2'b00, rt_root[l]});
    end
  end

  logic                   p3_v;
  gcsac_pkg::co_sb_t      p3_sb;
  logic [1:0][CORW-1:0]   p3_x, p3_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sb.big    <= rnd[0];
      p3_sb.az     <= rt_sb.az;
      p3_sb.negp   <= rt_sb.negp;
      p3_sb.ge_col <= rt_sb.ge_col;
      p3_sb.ge_row <= rt_sb.ge_row;
      p3_y[0]      <= rnd[1];
      p3_x[0]      <= CORW'(rt_sb.az);
      p3_y[1]      <= CORW'(rt_sb.ay);
      p3_x[1]      <= CORW'(rt_sb.ax);
    end
  end

  // Arctangents: lane 0 the polar angle, lane 1 the base azimuth magnitude.
  logic                   co_v;
  logic [1:0][ANGW-1:0]   co_ang;
  logic [$bits(gcsac_pkg::co_sb_t)-1:0] co_sb_raw;
  gcsac_pkg::co_sb_t      co_sb;

  gcsac_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   ($bits(gcsac_pkg::co_sb_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_v),
    .in_x      (p3_x),
    .in_y      (p3_y),
    .in_sb     (p3_sb),
    .out_valid (co_v),
    .out_angle (co_ang),
    .out_sb    (co_sb_raw)
  );

  assign co_sb = co_sb_raw;

  // Stage 4: quadrant correction, angle rounding and divider operands.
  logic signed [PHIW:0]   ps;
  logic signed [PHIW:0]   phi;
  logic [PHIW:0]          phi_rnd;
  logic [ANGW:0]          th_rnd;
  logic [ANGW+1-8-1:0]    pol_w;
  logic [PHIW+1-8-1:0]    azi_w;
  gcsac_pkg::dv_sb_t      p4_sb_next;
  logic [gcsac_pkg::DIV_NW-1:0] num_next;
  logic [gcsac_pkg::DIV_DW-1:0] den_next;

  always_comb begin
    ps = co_sb.negp ? -$signed({3'b000, co_ang[1]}) : $signed({3'b000, co_ang[1]});
    priority if (co_sb.ge_col && co_sb.ge_row) begin
      phi = $signed({3'b000, gcsac_pkg::DEG90}) - ps;
    end else if (co_sb.ge_col) begin
      phi = $signed({3'b000, co_ang[1]}) + $signed({3'b000, gcsac_pkg::DEG90});
    end else if (!co_sb.ge_row) begin
      phi = $signed({1'b0, gcsac_pkg::DEG270}) - ps;
    end else begin
      phi = $signed({3'b000, co_ang[1]}) + $signed({1'b0, gcsac_pkg::DEG270});
    end
    phi_rnd = (phi < 0) ? (PHIW+1)'(128) : (PHIW+1)'(phi) + (PHIW+1)'(128);
    azi_w   = phi_rnd[PHIW:8];
    th_rnd  = {1'b0, co_ang[0]} + (ANGW+1)'(128);
    pol_w   = th_rnd[ANGW:8];

    p4_sb_next.slant = (co_sb.big > ROOTW'(gcsac_pkg::DIST_MAX)) ?
                       gcsac_pkg::DIST_MAX : co_sb.big[gcsac_pkg::DISTW-1:0];
    p4_sb_next.polar = (pol_w > (ANGW+1-8)'(gcsac_pkg::POLAR_MAX)) ?
                       gcsac_pkg::POLAR_MAX : pol_w[gcsac_pkg::POLW-1:0];
    p4_sb_next.azi   = (azi_w > (PHIW+1-8)'(gcsac_pkg::AZI_MAX)) ?
                       gcsac_pkg::AZI_MAX : azi_w[gcsac_pkg::AZIW-1:0];
    p4_sb_next.zero  = (co_sb.big == '0);

    // Cosine = |z| / R rounded half up: (2|z| * 65536 + R) / (2R).
    num_next = {1'b0, co_sb.az, 17'd0} + gcsac_pkg::DIV_NW'(co_sb.big);
    den_next = {co_sb.big, 1'b0};
  end

  logic                          p4_v;
  gcsac_pkg::dv_sb_t             p4_sb;
  logic [gcsac_pkg::DIV_NW-1:0]  p4_num;
  logic [gcsac_pkg::DIV_DW-1:0]  p4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= co_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_sb  <= p4_sb_next;
      p4_num <= num_next;
      p4_den <= den_next;
    end
  end

  logic                          dv_v;
  logic [gcsac_pkg::DIV_QB-1:0]  dv_q;
  logic [$bits(gcsac_pkg::dv_sb_t)-1:0] dv_sb_raw;
  gcsac_pkg::dv_sb_t             dv_sb;

  gcsac_div #(
    .NW   (gcsac_pkg::DIV_NW),
    .DW   (gcsac_pkg::DIV_DW),
    .QB   (gcsac_pkg::DIV_QB),
    .SB_W ($bits(gcsac_pkg::dv_sb_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p4_v),
    .in_num    (p4_num),
    .in_den    (p4_den),
    .in_sb     (p4_sb),
    .out_valid (dv_v),
    .out_quo   (dv_q),
    .out_sb    (dv_sb_raw)
  );

  assign dv_sb = dv_sb_raw;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slant_distance <= dv_sb.slant;
      polar_angle    <= dv_sb.zero ? '0 : dv_sb.polar;
      polar_cosine   <= (dv_sb.zero || dv_q > gcsac_pkg::COS_ONE) ?
                        gcsac_pkg::COS_ONE : dv_q;
      azimuth        <= dv_sb.azi;
    end
  end

`ifndef SYNTHESIS
  a_stall_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> polar_cosine <= gcsac_pkg::COS_ONE)
    else $error("cosine above one");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (polar_angle <= gcsac_pkg::POLAR_MAX && azimuth <= gcsac_pkg::AZI_MAX))
    else $error("angle out of range");
`endif

endmodule

### dv/grid_cell_slant_angle_calc_checker.sv
`timescale 1ns / 1ps

module grid_cell_slant_angle_calc_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  done,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [gcsac_pkg::CFGIW-1:0]           cfg_index,
  input  logic [gcsac_pkg::FW-1:0]              cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [gcsac_pkg::IDXW-1:0]            cell_column,
  input  logic [gcsac_pkg::IDXW-1:0]            cell_row,
  input  logic signed [gcsac_pkg::FW-1:0]       east_offset,
  input  logic signed [gcsac_pkg::FW-1:0]       north_offset,
  input  logic signed [gcsac_pkg::FW-1:0]       cell_height,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [gcsac_pkg::DISTW-1:0]           slant_distance,
  input  logic [gcsac_pkg::POLW-1:0]            polar_angle,
  input  logic [gcsac_pkg::COSW-1:0]            polar_cosine,
  input  logic [gcsac_pkg::AZIW-1:0]            azimuth,
  output int                                    errors,
  output int                                    pending,
  output int                                    results
);
  import gcsac_pkg::*;

  localparam int STAGES = 20;
  localparam longint Q90 = 64'sd5898240;
  localparam longint Q270 = 64'sd17694720;
  localparam longint ARC_TAB [0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  typedef struct {
    logic [DISTW-1:0] slant;
    logic [POLW-1:0]  polar;
    logic [COSW-1:0]  cosine;
    logic [AZIW-1:0]  azi;
  } geom_t;

  geom_t geom_q[$];
  int mismatches;
  longint site_h;
  longint depth;
  logic [IDXW-1:0] site_col;
  logic [IDXW-1:0] site_row_r;

  function automatic longint unsigned rounded_root(longint unsigned s);
    longint unsigned q, rem, b;
    q = 0;
    rem = s;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= q + b) begin
        rem = rem - (q + b);
        q = (q >> 1) + b;
      end else begin
        q = q >> 1;
      end
      b = b >> 2;
    end
    return (rem > q) ? q + 1 : q;
  endfunction

  // Vectoring arctangent of yv over xv, both nonnegative, in 1/65536 degree.
  function automatic longint arc_q16(longint yv, longint xv);
    longint cx, cy, acc, dx, dy;
    cx = xv * 256;
    cy = yv * 256;
    acc = 0;
    if (yv == 0) return 0;
    if (xv == 0) return Q90;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx; cy = cy - dy; acc = acc + ((i < 23) ? ARC_TAB[i] : 0);
      end else begin
        cx = cx - dx; cy = cy + dy; acc = acc - ((i < 23) ? ARC_TAB[i] : 0);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > Q90) acc = Q90;
    return acc;
  endfunction

  function automatic longint unsigned to_fine(longint a, longint unsigned hi);
    longint unsigned v;
    if (a < 0) a = 0;
    v = longint'(a + 128) >> 8;
    return (v > hi) ? hi : v;
  endfunction

  function automatic geom_t predict_geometry(logic [IDXW-1:0] col, logic [IDXW-1:0] row,
                                             longint x, longint y, longint h);
    geom_t g;
    longint z, theta, p, phi;
    longint unsigned ax, ay, az, flat, big, surf, cosv;
    z = h - (site_h - depth);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    flat = ax * ax + ay * ay;
    big = rounded_root(flat + az * az);
    surf = rounded_root(flat);
    if (big == 0) cosv = 65536;
    else cosv = (2 * az * 65536 + big) / (2 * big);
    if (cosv > 65536) cosv = 65536;
    theta = arc_q16(longint'(surf), longint'(az));
    p = arc_q16(longint'(ay), longint'(ax));
    if ((x < 0 && y > 0) || (x > 0 && y < 0) || (x == 0 && y < 0)) p = -p;
    if (col >= site_col && row >= site_row_r) phi = Q90 - p;
    else if (col >= site_col) phi = ((p < 0) ? -p : p) + Q90;
    else if (row < site_row_r) phi = Q270 - p;
    else phi = ((p < 0) ? -p : p) + Q270;
    g.slant = (big > 1048575) ? DIST_MAX : big[DISTW-1:0];
    g.polar = POLW'(to_fine(theta, 23040));
    g.cosine = cosv[COSW-1:0];
    g.azi = AZIW'(to_fine(phi, 92160));
    return g;
  endfunction

  assign pending = geom_q.size();
  assign errors = mismatches + (done ? geom_q.size() : 0);

  always @(posedge clk) begin
    geom_t e;
    if (rst) begin
      site_h <= 0;
      depth <= 23648;
      site_col <= '0;
      site_row_r <= '0;
      mismatches <= 0;
      results <= 0;
      geom_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SITE_HEIGHT: site_h <= longint'($signed(cfg_data));
          CFG_DET_DEPTH:   depth <= longint'(cfg_data[DEPW-1:0]);
          CFG_SITE_COLUMN: site_col <= cfg_data[IDXW-1:0];
          CFG_SITE_ROW:    site_row_r <= cfg_data[IDXW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results <= results + 1;
        if (geom_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatches <= mismatches + 1;
        end else begin
          e = geom_q.pop_front();
          if (e.slant !== slant_distance || e.polar !== polar_angle ||
              e.cosine !== polar_cosine || e.azi !== azimuth) begin
            mismatches <= mismatches + 1;
            if (e.slant !== slant_distance)
              $error("slant_distance: expected %0d, got %0d", e.slant, slant_distance);
            if (e.polar !== polar_angle)
              $error("polar_angle: expected %0d, got %0d", e.polar, polar_angle);
            if (e.cosine !== polar_cosine)
              $error("polar_cosine: expected %0d, got %0d", e.cosine, polar_cosine);
            if (e.azi !== azimuth)
              $error("azimuth: expected %0d, got %0d", e.azi, azimuth);
          end
        end
      end
      if (in_valid && !in_stall)
        geom_q.push_back(predict_geometry(cell_column, cell_row, longint'(east_offset),
                                          longint'(north_offset), longint'(cell_height)));
    end
  end

endmodule

### dv/grid_cell_slant_angle_calc_core_tb.sv
`timescale 1ns / 1ps

module grid_cell_slant_angle_calc_core_tb;
  import gcsac_pkg::*;

  localparam int DRAIN = 70;
  localparam int WATCHDOG = 5000;
  localparam int PHASES = 7;
  localparam int PER_PHASE = 200;
  // An index past the register list; the block ignores writes to it.
  localparam logic [CFGIW-1:0] CFG_UNUSED = 3'd5;

  logic clk;
  logic rst;
  logic done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFGIW-1:0] cfg_index;
  logic [FW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [IDXW-1:0] cell_column;
  logic [IDXW-1:0] cell_row;
  logic signed [FW-1:0] east_offset;
  logic signed [FW-1:0] north_offset;
  logic signed [FW-1:0] cell_height;
  logic out_valid;
  logic out_stall;
  logic [DISTW-1:0] slant_distance;
  logic [POLW-1:0] polar_angle;
  logic [COSW-1:0] polar_cosine;
  logic [AZIW-1:0] azimuth;
  int errors;
  int pending;
  int results;
  int idle_cycles;
  int stall_pct;
  int cells_sent;
  bit hold_req;
  bit no_gaps;
  longint cur_site_h;
  longint cur_depth;
  int cur_col;
  int cur_row;

  grid_cell_slant_angle_calc_core dut (.*);

  grid_cell_slant_angle_calc_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint clamp19(longint v);
    if (v > 262143) return 262143;
    if (v < -262144) return -262144;
    return v;
  endfunction

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int k = 0; k < 400; k++) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
        left = 0;
      end else if (left > 0) begin
        left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        left = gap_len();
      end
    end
  end

  task automatic write_reg(logic [CFGIW-1:0] idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[FW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_site(longint sh, longint dep, int col, int row);
    write_reg(CFG_SITE_HEIGHT, sh);
    write_reg(CFG_DET_DEPTH, dep);
    write_reg(CFG_SITE_COLUMN, col);
    write_reg(CFG_SITE_ROW, row);
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_site_h = sh;
    cur_depth = dep;
    cur_col = col;
    cur_row = row;
  endtask

  task automatic send_cell(int col, int row, longint x, longint y, longint h);
    int g;
    in_valid <= 1'b1;
    cell_column <= col[IDXW-1:0];
    cell_row <= row[IDXW-1:0];
    east_offset <= x[FW-1:0];
    north_offset <= y[FW-1:0];
    cell_height <= h[FW-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random_cell();
    int r, col, row;
    longint x, y, h, zc;
    r = $urandom_range(0, 99);
    col = $urandom_range(0, 4095);
    row = $urandom_range(0, 4095);
    x = $signed($urandom_range(0, 524287)) - 262144;
    y = $signed($urandom_range(0, 524287)) - 262144;
    h = $signed($urandom_range(0, 524287)) - 262144;
    zc = cur_site_h - cur_depth;
    if (r < 40) begin
      x = $signed($urandom_range(0, 4000)) - 2000;
      y = $signed($urandom_range(0, 4000)) - 2000;
      h = clamp19(zc + $signed($urandom_range(0, 4000)) - 2000);
    end else if (r < 55) begin
      x = 0;
    end else if (r < 65) begin
      y = 0;
    end else if (r < 75) begin
      col = cur_col;
      row = ($urandom_range(0, 1) == 1) ? cur_row : row;
    end else if (r < 82) begin
      x = 0;
      y = 0;
      if ($urandom_range(0, 1) == 1) h = clamp19(zc);
    end
    send_cell(col, row, x, y, h);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    done <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cell_column <= '0;
    cell_row <= '0;
    east_offset <= '0;
    north_offset <= '0;
    cell_height <= '0;
    stall_pct = 20;
    hold_req = 0;
    no_gaps = 0;
    cells_sent = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_site(0, 23648, 2048, 2048);
        1: load_site(-262144, 0, 0, 0);
        2: load_site(262143, 262143, 4095, 4095);
        4: load_site(0, 262143, 4095, 0);
        default: load_site($signed($urandom_range(0, 524287)) - 262144,
                           $urandom_range(0, 262143), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
      endcase
      stall_pct = (ph % 3 == 0) ? 10 : (ph % 3 == 1) ? 0 : 50;
      no_gaps = (ph == 1 || ph == 2);
      if (ph == 0) begin
        // Cell at the detector, straight above, the axes, the field extremes,
        // flat line of sight, and all four quadrants around the site cell.
        send_cell(2048, 2048, 0, 0, -23648);
        send_cell(2048, 2048, 0, 0, 1000);
        send_cell(2048, 2048, 0, 5000, 0);
        send_cell(2048, 2048, 0, -5000, 0);
        send_cell(2048, 2048, 5000, 0, 0);
        send_cell(2048, 2048, -5000, 0, 0);
        send_cell(4095, 4095, 262143, 262143, 262143);
        send_cell(0, 0, -262144, -262144, -262144);
        send_cell(4095, 0, 262143, -262144, 262143);
        send_cell(0, 4095, -262144, 262143, -262144);
        send_cell(2100, 2100, 100, 0, -23648);
        send_cell(2100, 2100, 3000, 4000, 500);
        send_cell(2100, 100, 3000, -4000, 500);
        send_cell(100, 100, -3000, -4000, 500);
        send_cell(100, 3000, -3000, 4000, 500);
        send_cell(2047, 2048, -1, 1, -23648);
        send_cell(2048, 2047, 1, -1, -23647);
        send_cell(4095, 4095, 0, 0, 262143);
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 2 && n == 40) hold_req = 1;
        send_random_cell();
      end
      in_valid <= 1'b0;
      settle();
    end

    done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("Sent %0d grid cells over %0d site settings; %0d result words checked.",
             cells_sent, PHASES, results);
    $display("Covered quadrants, axis cases, detector-point cells and a long output hold.");
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
